@@ sv/rhm_pkg.sv @@
// ----------------------------------------------------------------------------
// rhm_pkg: shared definitions for the right-hand maze follower
// Grid size defaults, move codes, sequencer states and the right-hand pick.
// ----------------------------------------------------------------------------
package rhm_pkg;

    localparam int GRID_W_DEF = 16;
    localparam int GRID_H_DEF = 16;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    // offsets relative to heading, in right-hand priority order
    localparam logic [1:0] OFF_RIGHT    = 2'd1;
    localparam logic [1:0] OFF_STRAIGHT = 2'd0;
    localparam logic [1:0] OFF_LEFT     = 2'd3;
    localparam logic [1:0] OFF_BACK     = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic       found;
        logic [1:0] dir;
    } pick_t;

    // first open neighbour in right, straight, left, back order
    function automatic pick_t right_hand_pick(input logic [1:0] hd, input logic [3:0] open);
        logic [1:0] offs [4];
        logic [1:0] d;
        pick_t      p;
        offs[0] = OFF_RIGHT;
        offs[1] = OFF_STRAIGHT;
        offs[2] = OFF_LEFT;
        offs[3] = OFF_BACK;
        p.found = 1'b0;
        p.dir   = hd;
        for (int k = 3; k >= 0; k--)
        begin
            d = hd + offs[k];
            if (open[d])
            begin
                p.found = 1'b1;
                p.dir   = d;
            end
        end
        return p;
    endfunction

endpackage

@@ sv/rhm_if.sv @@
// ----------------------------------------------------------------------------
// rhm interfaces: valid/ready channels of the maze follower
// Position channel in, move command channel out.
// ----------------------------------------------------------------------------
interface rhm_pos_if;
    logic       valid;
    logic       ready;
    logic [3:0] pos_x;
    logic [3:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface rhm_move_if;
    logic       valid;
    logic       ready;
    logic [1:0] move_dir;
    logic       wall_learned;

    modport source (output valid, output move_dir, output wall_learned, input ready);
    modport sink   (input valid, input move_dir, input wall_learned, output ready);
endinterface

@@ sv/rhm_ram.sv @@
// ----------------------------------------------------------------------------
// rhm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rhm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/right_hand_maze_follower.sv @@
// ----------------------------------------------------------------------------
// right_hand_maze_follower: right-hand wall follower with learned walls
// Blocked-cell map in RAM, heading state in registers, one move per position.
// ----------------------------------------------------------------------------
// Usage:
//   pos  (sink)   : one transaction per robot step, carrying pos_x / pos_y.
//   move (source) : one transaction per step, carrying move_dir and
//                   wall_learned (set when the cell ahead was just marked).
// Timing: the four neighbour cells of an accepted position are read one
//   after another through the single read port of the map RAM, then the
//   decide state picks the move and writes back. A new position is taken
//   in the decide state of the previous one.
// Reset: rst_n clears heading and position state, then a clearing pass
//   writes every map cell, with pos.ready low.
// Stall: the result sits in an output register. A new position is accepted
//   while it waits; the next result holds in the decide cycle until the
//   output register frees up.
// ----------------------------------------------------------------------------
module right_hand_maze_follower #(
    parameter int GRID_W = rhm_pkg::GRID_W_DEF,
    parameter int GRID_H = rhm_pkg::GRID_H_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rhm_pos_if.sink     pos,
    rhm_move_if.source  move
);

    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [6:0] GW = 7'(GRID_W);
    localparam logic [6:0] GH = 7'(GRID_H);

    rhm_pkg::state_t state_reg, state_next;
    logic [1:0]    rd_cnt_reg, rd_cnt_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [3:0] px_reg, py_reg;
    logic [3:0] last_x_reg, last_x_next;
    logic [3:0] last_y_reg, last_y_next;
    logic [1:0] heading_reg, heading_next;
    logic [1:0] prior_reg, prior_next;
    logic [1:0] last_move_reg, last_move_next;
    logic [2:0] blk_reg;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_dir_reg;
    logic       out_wall_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic          wdata;
    logic [AW-1:0] raddr;
    logic          rdata;

    logic [3:0]    inb;
    logic [AW-1:0] nidx [4];
    logic [3:0]    blk;
    logic [3:0]    open;
    logic          out_free;
    logic          in_acc;
    logic          finish;
    logic          learn;
    logic [1:0]    new_dir;
    rhm_pkg::pick_t pick;

    rhm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // neighbour bounds and cell indexes of the held position
    always_comb
    begin
        logic [6:0] x7, y7;
        logic [6:0] nx [4];
        logic [6:0] ny [4];
        logic [13:0] lin;
        x7 = {3'b0, px_reg};
        y7 = {3'b0, py_reg};
        nx[rhm_pkg::DIR_UP]    = x7;
        ny[rhm_pkg::DIR_UP]    = y7 - 7'd1;
        nx[rhm_pkg::DIR_RIGHT] = x7 + 7'd1;
        ny[rhm_pkg::DIR_RIGHT] = y7;
        nx[rhm_pkg::DIR_DOWN]  = x7;
        ny[rhm_pkg::DIR_DOWN]  = y7 + 7'd1;
        nx[rhm_pkg::DIR_LEFT]  = x7 - 7'd1;
        ny[rhm_pkg::DIR_LEFT]  = y7;
        inb[rhm_pkg::DIR_UP]    = (py_reg != 4'd0) && (x7 < GW) && (ny[0] < GH);
        inb[rhm_pkg::DIR_RIGHT] = (nx[1] < GW) && (y7 < GH);
        inb[rhm_pkg::DIR_DOWN]  = (x7 < GW) && (ny[2] < GH);
        inb[rhm_pkg::DIR_LEFT]  = (px_reg != 4'd0) && (nx[3] < GW) && (y7 < GH);
        for (int d = 0; d < 4; d++)
        begin
            lin = {7'b0, ny[d]} * {7'b0, GW} + {7'b0, nx[d]};
            nidx[d] = inb[d] ? lin[AW-1:0] : '0;
        end
    end

    assign blk  = {rdata, blk_reg};
    assign open = inb & ~blk;
    assign pick = rhm_pkg::right_hand_pick(heading_reg, open);

    assign learn = (px_reg == last_x_reg) && (py_reg == last_y_reg)
                   && inb[heading_reg] && !blk[heading_reg];

    assign out_free = !out_valid_reg || move.ready;
    assign finish   = (state_reg == rhm_pkg::ST_DECIDE) && out_free;
    assign pos.ready = (state_reg == rhm_pkg::ST_IDLE) || finish;
    assign in_acc   = pos.valid && pos.ready;

    assign new_dir = learn ? prior_reg : (pick.found ? pick.dir : last_move_reg);

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        heading_next   = heading_reg;
        prior_next     = prior_reg;
        last_move_next = last_move_reg;
        out_valid_next = out_valid_reg && !move.ready;
        we             = 1'b0;
        waddr          = nidx[heading_reg];
        wdata          = 1'b1;
        raddr          = nidx[rd_cnt_reg];

        case (state_reg)
            rhm_pkg::ST_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                wdata        = 1'b0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = rhm_pkg::ST_IDLE;
                end
            end
            rhm_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next  = rhm_pkg::ST_READ;
                    rd_cnt_next = 2'd0;
                end
            end
            rhm_pkg::ST_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 2'd1;
                if (rd_cnt_reg == 2'd3)
                begin
                    state_next = rhm_pkg::ST_DECIDE;
                end
            end
            rhm_pkg::ST_DECIDE:
            begin
                // keep the left neighbour on the read port while stalled
                raddr = nidx[rhm_pkg::DIR_LEFT];
                if (finish)
                begin
                    we             = learn;
                    last_x_next    = px_reg;
                    last_y_next    = py_reg;
                    last_move_next = new_dir;
                    out_valid_next = 1'b1;
                    if (learn)
                    begin
                        heading_next = prior_reg;
                    end
                    else
                    begin
                        prior_next = heading_reg;
                        if (pick.found)
                        begin
                            heading_next = pick.dir;
                        end
                    end
                    if (in_acc)
                    begin
                        state_next  = rhm_pkg::ST_READ;
                        rd_cnt_next = 2'd0;
                    end
                    else
                    begin
                        state_next = rhm_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rhm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rhm_pkg::ST_CLEAR;
            rd_cnt_reg    <= 2'd0;
            clr_cnt_reg   <= '0;
            last_x_reg    <= 4'd0;
            last_y_reg    <= 4'd0;
            heading_reg   <= rhm_pkg::DIR_UP;
            prior_reg     <= rhm_pkg::DIR_UP;
            last_move_reg <= rhm_pkg::DIR_UP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            heading_reg   <= heading_next;
            prior_reg     <= prior_next;
            last_move_reg <= last_move_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: position, captured map bits, result
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px_reg <= pos.pos_x;
            py_reg <= pos.pos_y;
        end
        // data of the read issued last cycle
        if ((state_reg == rhm_pkg::ST_READ) && (rd_cnt_reg != 2'd0))
        begin
            blk_reg[rd_cnt_reg - 2'd1] <= rdata;
        end
        if (finish)
        begin
            out_dir_reg  <= new_dir;
            out_wall_reg <= learn;
        end
    end

    assign move.valid        = out_valid_reg;
    assign move.move_dir     = out_dir_reg;
    assign move.wall_learned = out_wall_reg;

endmodule
